### sv/agpb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package agpb_pkg;

  // Coordinate and glyph-dimension widths of the internal state.
  localparam int COORD_BITS = 16;
  localparam int DIM_BITS   = 8;
  localparam int DIM_EXT    = DIM_BITS + 1;

  // Two lanes, one per nibble of a bitmap byte.
  localparam int LANES = 2;

  // Blend arithmetic: numerator width and the reciprocal of 15 in Q15.
  localparam int          NUM_BITS    = 10;
  localparam int          RECIP_BITS  = 12;
  localparam int          PROD_BITS   = NUM_BITS + RECIP_BITS;
  localparam int          RECIP_SHIFT = 15;
  localparam logic [11:0] RECIP_15    = 12'd2185;
  localparam logic [3:0]  ALPHA_MAX   = 4'd15;
  localparam logic [3:0]  ROUND_HALF  = 4'd7;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_GLYPH  = 2'd1,
    KIND_BITMAP = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_FG_COLOR = 2'd0,
    REG_BG_COLOR = 2'd1,
    REG_ASCENT   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [7:0]  x_offset;
    logic signed [7:0]  y_offset;
    logic [7:0]         glyph_width;
    logic [7:0]         glyph_height;
    logic signed [7:0]  x_advance;
    logic [7:0]         alpha_pair;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [15:0]        pixel_color;
    logic               last_of_item;
  } pixel_t;

  // Work handed to one blend lane.
  typedef struct packed {
    logic [3:0]  alpha;
    logic [15:0] fg;
    logic [15:0] bg;
    logic [15:0] x;
    logic [15:0] y;
  } lane_req_t;

  // What the pen walker hands to the lanes for one accepted request.
  typedef struct packed {
    logic [LANES-1:0]            hit;
    lane_req_t [LANES-1:0]       lane;
  } walk_t;

endpackage

`default_nettype wire

### sv/agpb_walk.sv
`timescale 1ns / 1ps
`default_nettype none

module agpb_walk
  import agpb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        take,
  input  wire in_req_t     req,
  output walk_t            walk
);

  logic [15:0]          fg_color;
  logic [15:0]          bg_color;
  logic signed [7:0]    ascent;

  logic [COORD_BITS-1:0] pen_x;
  logic [COORD_BITS-1:0] baseline_y;
  logic [COORD_BITS-1:0] origin_x;
  logic [COORD_BITS-1:0] origin_y;
  logic [DIM_BITS-1:0]   cur_width;
  logic [DIM_BITS-1:0]   cur_height;
  logic [DIM_BITS-1:0]   column;
  logic [DIM_BITS-1:0]   row;

  logic [DIM_BITS-1:0]   col1, row1, col2, row2;
  logic                  live0, live1;

  // Moves the pixel cursor one place on, row-major through the glyph.
  function automatic logic [2*DIM_BITS-1:0] step_pos(input logic [DIM_BITS-1:0] c,
                                                      input logic [DIM_BITS-1:0] r,
                                                      input logic [DIM_BITS-1:0] w);
    logic [DIM_EXT-1:0] c_inc;
    c_inc = DIM_EXT'(c) + DIM_EXT'(1);
    if (c_inc >= DIM_EXT'(w)) begin
      step_pos = {{DIM_BITS{1'b0}}, DIM_BITS'(r + DIM_BITS'(1))};
    end else begin
      step_pos = {c_inc[DIM_BITS-1:0], r};
    end
  endfunction

  // Screen coordinate of a glyph pixel, returned as its low 16 bits.
  function automatic logic [15:0] place(input logic [COORD_BITS-1:0] o,
                                        input logic [DIM_BITS-1:0] d);
    logic [COORD_BITS-1:0] s;
    s = COORD_BITS'(33'(o) + 33'(d));
    place = 16'(s);
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= 16'hFFFF;
      bg_color <= 16'h0000;
      ascent   <= 8'sd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FG_COLOR: fg_color <= cfg_wdata;
        REG_BG_COLOR: bg_color <= cfg_wdata;
        REG_ASCENT:   ascent   <= cfg_wdata[7:0];
        default:      ;
      endcase
    end
  end

  // Cursor positions of both nibbles, the second following the first.
  always_comb begin
    live0 = (cur_width != '0) && (row < cur_height);
    if (live0) begin
      {col1, row1} = step_pos(column, row, cur_width);
    end else begin
      col1 = column;
      row1 = row;
    end
    live1 = (cur_width != '0) && (row1 < cur_height);
    if (live1) begin
      {col2, row2} = step_pos(col1, row1, cur_width);
    end else begin
      col2 = col1;
      row2 = row1;
    end
  end

  // Lane requests: the high nibble goes to lane 0, the low one to lane 1.
  always_comb begin
    walk.hit[0] = (req.kind == KIND_BITMAP) && live0 && (req.alpha_pair[7:4] != 4'd0);
    walk.hit[1] = (req.kind == KIND_BITMAP) && live1 && (req.alpha_pair[3:0] != 4'd0);
    walk.lane[0].alpha = req.alpha_pair[7:4];
    walk.lane[1].alpha = req.alpha_pair[3:0];
    walk.lane[0].x     = place(origin_x, column);
    walk.lane[0].y     = place(origin_y, row);
    walk.lane[1].x     = place(origin_x, col1);
    walk.lane[1].y     = place(origin_y, row1);
    walk.lane[0].fg    = fg_color;
    walk.lane[1].fg    = fg_color;
    walk.lane[0].bg    = bg_color;
    walk.lane[1].bg    = bg_color;
  end

  // Pen, glyph and cursor state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x      <= '0;
      baseline_y <= '0;
      origin_x   <= '0;
      origin_y   <= '0;
      cur_width  <= '0;
      cur_height <= '0;
      column     <= '0;
      row        <= '0;
    end else if (take) begin
      unique case (req.kind)
        KIND_START: begin
          pen_x      <= COORD_BITS'(32'(req.start_x));
          baseline_y <= COORD_BITS'(32'(req.start_y) + 32'(ascent));
        end
        KIND_GLYPH: begin
          origin_x   <= COORD_BITS'(pen_x + COORD_BITS'(32'(req.x_offset)));
          origin_y   <= COORD_BITS'(baseline_y + COORD_BITS'(32'(req.y_offset)));
          cur_width  <= DIM_BITS'(req.glyph_width);
          cur_height <= DIM_BITS'(req.glyph_height);
          column     <= '0;
          row        <= '0;
          pen_x      <= COORD_BITS'(pen_x + COORD_BITS'(32'(req.x_advance)));
        end
        KIND_BITMAP: begin
          column <= col2;
          row    <= row2;
        end
        KIND_NONE: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/agpb_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module agpb_lane
  import agpb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      en1,
  input  wire logic      en2,
  input  wire lane_req_t req,
  output pixel_t         pix
);

  logic [3:0]          inv;
  logic [NUM_BITS-1:0] num_r_next, num_g_next, num_b_next;
  logic [NUM_BITS-1:0] num_r, num_g, num_b;
  logic [15:0]         x1, y1;
  logic [PROD_BITS-1:0] prod_r, prod_g, prod_b;

  // Weighted sums per channel, with the rounding term.
  always_comb begin
    inv = ALPHA_MAX - req.alpha;
    num_r_next = NUM_BITS'(req.fg[15:11]) * NUM_BITS'(req.alpha)
               + NUM_BITS'(req.bg[15:11]) * NUM_BITS'(inv) + NUM_BITS'(ROUND_HALF);
    num_g_next = NUM_BITS'(req.fg[10:5]) * NUM_BITS'(req.alpha)
               + NUM_BITS'(req.bg[10:5]) * NUM_BITS'(inv) + NUM_BITS'(ROUND_HALF);
    num_b_next = NUM_BITS'(req.fg[4:0]) * NUM_BITS'(req.alpha)
               + NUM_BITS'(req.bg[4:0]) * NUM_BITS'(inv) + NUM_BITS'(ROUND_HALF);
  end

  // First stage: sums and position.
  always_ff @(posedge clk) begin
    if (en1) begin
      num_r <= num_r_next;
      num_g <= num_g_next;
      num_b <= num_b_next;
      x1    <= req.x;
      y1    <= req.y;
    end
  end

  // Division by 15 as a multiply by its Q15 reciprocal; exact below 1000.
  always_comb begin
    prod_r = PROD_BITS'(num_r) * PROD_BITS'(RECIP_15);
    prod_g = PROD_BITS'(num_g) * PROD_BITS'(RECIP_15);
    prod_b = PROD_BITS'(num_b) * PROD_BITS'(RECIP_15);
  end

  // Second stage: packed RGB565 pixel.
  always_ff @(posedge clk) begin
    if (en2) begin
      pix.pixel_x      <= x1;
      pix.pixel_y      <= y1;
      pix.pixel_color  <= {prod_r[RECIP_SHIFT +: 5], prod_g[RECIP_SHIFT +: 6],
                           prod_b[RECIP_SHIFT +: 5]};
      pix.last_of_item <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### sv/agpb_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module agpb_merge
  import agpb_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire logic [LANES-1:0]       mask,
  input  wire pixel_t [LANES-1:0]     pix,
  output logic                        room,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output pixel_t                      out_data
);

  logic [LANES-1:0]   pend;
  pixel_t [LANES-1:0] slot;
  logic               fire;

  // Lane 0 goes first; the last pending pixel carries the end mark.
  always_comb begin
    out_valid = |pend;
    fire      = out_valid && out_ready;
    out_data  = pend[0] ? slot[0] : slot[1];
    out_data.last_of_item = !(pend[0] && pend[1]);
    room      = (pend == '0) || (fire && !(pend[0] && pend[1]));
  end

  // Pending flags: loaded from the lanes, cleared one per request sent.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (load) begin
      pend <= mask;
    end else if (fire) begin
      if (pend[0]) begin
        pend[0] <= 1'b0;
      end else begin
        pend[1] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= pix;
    end
  end

endmodule

`default_nettype wire

### sv/antialiased_glyph_pixel_blender.sv
// Channel | Direction | Payload            | Handshake
// in      | input     | in_req_t in_data   | in_valid / in_ready
// out     | output    | pixel_t out_data   | out_valid / out_ready
// cfg     | input     | cfg_index, wdata   | cfg_wr_en, no wait
//
// A bitmap byte with two drawn pixels holds the merge stage until both have been sent.
// The single output port, one pixel per cycle while out_ready is high, sets the pace.
// A pixel passes through two blend stages and the merge stage on its way out.
// Reset is synchronous and clears pen, glyph, configuration and stage-mask state; lane data is not reset.
// A stall on the output backs up through the merge and blend stages to in_ready.
`timescale 1ns / 1ps
`default_nettype none

module antialiased_glyph_pixel_blender
  import agpb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_req_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output pixel_t           out_data,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  walk_t              walk;
  logic               take;
  logic [LANES-1:0]   s1_mask, s2_mask;
  logic               s1_adv, s2_adv;
  logic               room;
  pixel_t [LANES-1:0] lane_pix;

  // Stage advance, from the merge stage back to the input.
  always_comb begin
    s2_adv   = (s2_mask == '0) || room;
    s1_adv   = (s1_mask == '0) || s2_adv;
    in_ready = s1_adv;
    take     = in_valid && in_ready;
  end

  agpb_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .req       (in_data),
    .walk      (walk)
  );

  // Which lanes hold a pixel in each blend stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_mask <= '0;
      s2_mask <= '0;
    end else begin
      if (s1_adv) begin
        s1_mask <= take ? walk.hit : '0;
      end
      if (s2_adv) begin
        s2_mask <= s1_mask;
      end
    end
  end

  // One blend lane per nibble.
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    agpb_lane u_lane (
      .clk (clk),
      .en1 (s1_adv),
      .en2 (s2_adv),
      .req (walk.lane[i]),
      .pix (lane_pix[i])
    );
  end

  agpb_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      ((s2_mask != '0) && room),
    .mask      (s2_mask),
    .pix       (lane_pix),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### sv/agpb_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module agpb_checker
  import agpb_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire pixel_t      out_data
);

  // A stalled pixel request holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output request changed while stalled");

  // Nothing is offered straight after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // The second pixel of a byte follows at once.
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_of_item |=> out_valid)
    else $error("second pixel of a byte missing");

  // The input only stalls when a pixel waits at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no pixel pending");

endmodule

bind antialiased_glyph_pixel_blender agpb_checker u_agpb_checker (.*);

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import agpb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_req_t     in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  pixel_t      out_data;
  logic        cfg_wr_en = 1'b0;
  cfg_reg_t    cfg_index = REG_FG_COLOR;
  logic [15:0] cfg_wdata = '0;

  // Requests waiting to be sent and pixels still owed by the block.
  in_req_t text_reqs[$];
  pixel_t  pixels_due[$];

  // Our own copy of the registers and of the pen and glyph state.
  logic [15:0] fg_reg   = 16'hFFFF;
  logic [15:0] bg_reg   = 16'h0000;
  logic [7:0]  asc_reg  = 8'h00;
  logic [15:0] pen_x    = '0;
  logic [15:0] base_y   = '0;
  logic [15:0] org_x    = '0;
  logic [15:0] org_y    = '0;
  logic [7:0]  cur_w    = '0;
  logic [7:0]  cur_h    = '0;
  logic [7:0]  col      = '0;
  logic [7:0]  row      = '0;

  int errors      = 0;
  int tx_gap      = 0;
  int rx_wait     = 0;
  int rx_draw     = 0;
  int idle_cycles = 0;
  bit no_idle     = 1'b0;

  antialiased_glyph_pixel_blender u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Sign-extend an 8-bit offset to coordinate width.
  function automatic logic [15:0] sx8(logic [7:0] v);
    return {{8{v[7]}}, v};
  endfunction

  // Blend the foreground over the background per RGB565 channel, rounding the
  // division by 15.
  function automatic logic [15:0] blend_rgb565(logic [3:0] a);
    int inv, r, g, b;
    if (a == ALPHA_MAX) return fg_reg;
    inv = 15 - int'(a);
    r = (int'(fg_reg[15:11]) * int'(a) + int'(bg_reg[15:11]) * inv + 7) / 15;
    g = (int'(fg_reg[10:5]) * int'(a) + int'(bg_reg[10:5]) * inv + 7) / 15;
    b = (int'(fg_reg[4:0]) * int'(a) + int'(bg_reg[4:0]) * inv + 7) / 15;
    return {r[4:0], g[5:0], b[4:0]};
  endfunction

  // Advance the pen and glyph state for one accepted request and queue the
  // pixels that it should produce.
  function automatic void render_request(in_req_t r);
    pixel_t     drawn[$];
    pixel_t     p;
    logic [3:0] a;
    case (r.kind)
      KIND_START: begin
        pen_x  = r.start_x;
        base_y = r.start_y + sx8(asc_reg);
      end
      KIND_GLYPH: begin
        org_x = pen_x + sx8(r.x_offset);
        org_y = base_y + sx8(r.y_offset);
        cur_w = r.glyph_width;
        cur_h = r.glyph_height;
        col   = '0;
        row   = '0;
        pen_x = pen_x + sx8(r.x_advance);
      end
      KIND_BITMAP: begin
        for (int i = 0; i < LANES; i++) begin
          a = (i == 0) ? r.alpha_pair[7:4] : r.alpha_pair[3:0];
          if (cur_w != 0 && row < cur_h) begin
            if (a != 0) begin
              p.pixel_x      = org_x + {8'd0, col};
              p.pixel_y      = org_y + {8'd0, row};
              p.pixel_color  = blend_rgb565(a);
              p.last_of_item = 1'b0;
              drawn.push_back(p);
            end
            if (int'(col) + 1 >= int'(cur_w)) begin
              col = '0;
              row = row + 8'd1;
            end else begin
              col = col + 8'd1;
            end
          end
        end
        if (drawn.size() != 0) drawn[drawn.size() - 1].last_of_item = 1'b1;
        foreach (drawn[k]) pixels_due.push_back(drawn[k]);
      end
      default: ;
    endcase
  endfunction

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected 0x%04h, actual 0x%04h", $time, name, want, got);
    end
  endfunction

  // Compare a received pixel against the oldest one owed.
  function automatic void check_pixel(pixel_t got);
    pixel_t want;
    if (pixels_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected pixel: expected none, actual x=%0d y=%0d colour=0x%04h last=%0b",
               $time, got.pixel_x, got.pixel_y, got.pixel_color, got.last_of_item);
    end else begin
      want = pixels_due.pop_front();
      compare_field("pixel_x", want.pixel_x, got.pixel_x);
      compare_field("pixel_y", want.pixel_y, got.pixel_y);
      compare_field("pixel_color", want.pixel_color, got.pixel_color);
      compare_field("last_of_item", {15'd0, want.last_of_item}, {15'd0, got.last_of_item});
    end
  endfunction

  // A request with every field random, so that unused fields are exercised too.
  function automatic in_req_t noise_req(kind_t k);
    in_req_t r;
    r.kind         = k;
    r.start_x      = 16'($urandom);
    r.start_y      = 16'($urandom);
    r.x_offset     = 8'($urandom);
    r.y_offset     = 8'($urandom);
    r.glyph_width  = 8'($urandom);
    r.glyph_height = 8'($urandom);
    r.x_advance    = 8'($urandom);
    r.alpha_pair   = 8'($urandom);
    return r;
  endfunction

  function automatic void send_start(logic [15:0] x, logic [15:0] y);
    in_req_t r;
    r = noise_req(KIND_START);
    r.start_x = x;
    r.start_y = y;
    text_reqs.push_back(r);
  endfunction

  function automatic void send_glyph(logic [7:0] xo, logic [7:0] yo, logic [7:0] w,
                                     logic [7:0] h, logic [7:0] adv);
    in_req_t r;
    r = noise_req(KIND_GLYPH);
    r.x_offset     = xo;
    r.y_offset     = yo;
    r.glyph_width  = w;
    r.glyph_height = h;
    r.x_advance    = adv;
    text_reqs.push_back(r);
  endfunction

  function automatic void send_byte(logic [7:0] b);
    in_req_t r;
    r = noise_req(KIND_BITMAP);
    r.alpha_pair = b;
    text_reqs.push_back(r);
  endfunction

  // Alphas lean towards the transparent and opaque ends.
  function automatic logic [3:0] rand_alpha();
    int pick;
    pick = $urandom_range(0, 3);
    if (pick == 0) return 4'd0;
    if (pick == 1) return ALPHA_MAX;
    return 4'($urandom_range(1, 14));
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed glyphs with random bitmaps, mixed with pen moves,
  // stray bytes and unused kinds.
  function automatic void random_text(int n_items);
    int count, pick, w, h, nbytes;
    count = 0;
    while (count < n_items) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        text_reqs.push_back(noise_req(KIND_NONE));
      end else if (pick == 1) begin
        send_byte(8'($urandom));
        count++;
      end else if (pick <= 3) begin
        send_start(rand_coord(), rand_coord());
        count++;
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          w = $urandom_range(0, 255);
          h = $urandom_range(0, 255);
        end else begin
          w = $urandom_range(0, 6);
          h = $urandom_range(0, 5);
        end
        send_glyph(8'($urandom), 8'($urandom), 8'(w), 8'(h), 8'($urandom));
        nbytes = (w * h + 1) / 2;
        if (nbytes > 12) nbytes = $urandom_range(1, 12);
        nbytes += $urandom_range(0, 1);
        repeat (nbytes) send_byte({rand_alpha(), rand_alpha()});
        count += 1 + nbytes;
      end
    end
  endfunction

  // One register write; our copy follows at once, as the block is idle.
  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_FG_COLOR: fg_reg  = val;
      REG_BG_COLOR: bg_reg  = val;
      REG_ASCENT:   asc_reg = val[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Hold off until every request is sent and every pixel has come back, then
  // allow the pipeline to empty of requests that draw nothing. The check is
  // made on the falling edge, once the driver and monitor have settled.
  task automatic drain();
    while (text_reqs.size() != 0 || in_valid || pixels_due.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Request driver with a random gap after each request.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      if (in_valid && in_ready) render_request(in_data);
      if (!in_valid || in_ready) begin
        if (tx_gap != 0) begin
          in_valid <= 1'b0;
          tx_gap   <= tx_gap - 1;
        end else if (text_reqs.size() != 0) begin
          in_data  <= text_reqs.pop_front();
          in_valid <= 1'b1;
          tx_gap   <= no_idle ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Pixel monitor with a random stall after each pixel.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else if (out_valid && out_ready) begin
      check_pixel(out_data);
      rx_draw = no_idle ? 0 : $urandom_range(0, 3);
      rx_wait   <= rx_draw;
      out_ready <= (rx_draw == 0);
    end else if (rx_wait != 0) begin
      rx_wait   <= rx_wait - 1;
      out_ready <= (rx_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: too long without any handshake means the block has hung.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus sequence: directed text under reset settings, then random text
  // under a series of colour and ascent settings.
  initial begin
    logic [15:0] fg_v, bg_v;
    logic [7:0]  asc_v;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Bytes before any header fall on an empty glyph; the unused kind does nothing.
    send_byte(8'hFF);
    text_reqs.push_back(noise_req(KIND_NONE));
    // Extreme pen and offsets; a 3-wide glyph has rows ending mid-byte.
    send_start(16'h7FFF, 16'h8000);
    send_glyph(8'h7F, 8'h80, 8'd3, 8'd2, 8'h80);
    send_byte(8'hF1);
    send_byte(8'h0F);
    send_byte(8'h7A);
    // Past the end of the glyph.
    send_byte(8'hFF);
    // Zero width, then the largest glyph with wrapping coordinates.
    send_glyph(8'h00, 8'h00, 8'd0, 8'd5, 8'h01);
    send_byte(8'hFF);
    send_glyph(8'h80, 8'h7F, 8'd255, 8'd255, 8'h7F);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h12);
    // A single-pixel glyph: the second nibble is already past the end.
    send_start(16'h8000, 16'h7FFF);
    send_glyph(8'h00, 8'h00, 8'd1, 8'd1, 8'h00);
    send_byte(8'hFF);
    // Zero height.
    send_glyph(8'h01, 8'h01, 8'd4, 8'd0, 8'h03);
    send_byte(8'hEE);
    // A new text in the middle of a glyph leaves the glyph running.
    send_glyph(8'h00, 8'h00, 8'd2, 8'd2, 8'h02);
    send_byte(8'hC3);
    send_start(16'd100, 16'hFFFB);
    send_byte(8'h3C);
    drain();

    for (int p = 1; p <= 8; p++) begin
      case (p)
        1: begin
          fg_v = 16'h0000; bg_v = 16'hFFFF; asc_v = 8'h80;
        end
        2: begin
          fg_v = 16'hFFFF; bg_v = 16'h0000; asc_v = 8'h7F;
        end
        3: begin
          fg_v = 16'hF800; bg_v = 16'h07E0; asc_v = 8'h00;
        end
        default: begin
          fg_v = 16'($urandom); bg_v = 16'($urandom); asc_v = 8'($urandom);
        end
      endcase
      write_reg(REG_FG_COLOR, fg_v);
      write_reg(REG_BG_COLOR, bg_v);
      write_reg(REG_ASCENT, {{8{asc_v[7]}}, asc_v});
      no_idle = (p == 3 || p == 6);
      random_text(60);
      drain();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
